/* src/gss_pkg.sv */
package gss_pkg;

  localparam int unsigned NumChan    = 6;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned NumWeights = 8;
  localparam int unsigned Taps       = 8;
  localparam int unsigned Depth      = 8;
  localparam int unsigned SlotW      = $clog2(Depth);
  localparam int unsigned WIdxW      = $clog2(NumWeights);
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned DataW      = NumChan * SampleW;
  // Sample (signed or unsigned per channel) times unsigned weight, both taken as 17-bit signed.
  localparam int unsigned ProdW      = (SampleW + 1) + (WeightW + 1);
  localparam int unsigned AccW       = ProdW + SlotW + 1;
  localparam int unsigned FracW      = WeightW;

  typedef logic [NumChan-1:0][SampleW-1:0] hist_word_t;
  typedef logic [WeightW-1:0]              weight_t;

  // Action codes carried on tuser.
  localparam logic ActStart = 1'b0;
  localparam logic ActAdd   = 1'b1;

  // Channel order: x, y, pressure, azimuth, altitude, jitter.
  localparam logic [NumChan-1:0] ChanSigned = 6'b011011;

  function automatic weight_t weight_reset(input logic [WIdxW-1:0] idx);
    weight_t w;
    case (idx)
      3'd0, 3'd1: w = 16'd16384;
      3'd2, 3'd3: w = 16'd8192;
      default:    w = 16'd4096;
    endcase
    return w;
  endfunction

endpackage

/* src/gaussian_stylus_smoother_top.sv */
// Six-channel stylus smoother. A word with tuser = 0 starts a stroke: the
// history is set to that sample and the sample comes back unchanged through
// StFinish and the output register once it is free. A word with tuser = 1 is
// stored as the newest entry and the block returns, per channel, the sum of
// the newest eight samples times weight_0..weight_7 (unsigned Q0.16), rounded
// to nearest with ties upwards and saturated to the channel's range. The
// single read port of the history memory is read once per tap. One word is in
// work at a time; tready is high only while the block is idle. Weights are to
// be written through the cfg port only while the block is idle; the block
// itself does not enforce this. Indices above 7 are ignored.
module gaussian_stylus_smoother_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: sample_x, sample_y, sample_pressure, sample_azimuth,
  // sample_altitude, sample_jitter, 16 bits each from bit 0 up.
  input  logic [gss_pkg::DataW-1:0]    s_axis_tdata,
  // tuser: action.
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: smooth_x, smooth_y, smooth_pressure, smooth_azimuth,
  // smooth_altitude, smooth_jitter, 16 bits each from bit 0 up.
  output logic [gss_pkg::DataW-1:0]    m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gss_pkg::WeightW-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StWrite,
    StRead,
    StDrain,
    StFinish
  } state_e;

  localparam logic [gss_pkg::SlotW-1:0] TapLast = gss_pkg::SlotW'(gss_pkg::Taps - 1);
  localparam int unsigned QW = gss_pkg::AccW - gss_pkg::FracW;

  state_e                          state_q;
  logic [gss_pkg::SlotW-1:0]       slot_q;
  logic [gss_pkg::SlotW-1:0]       tap_q;
  logic [gss_pkg::Depth-1:0]       vld_q;
  gss_pkg::hist_word_t             fill_q;
  gss_pkg::hist_word_t             in_q;
  logic                            is_start_q;
  logic                            out_vld_q;
  gss_pkg::hist_word_t             out_q;
  gss_pkg::weight_t                weight_q [gss_pkg::NumWeights];

  gss_pkg::hist_word_t             hist_mem [gss_pkg::Depth];
  gss_pkg::hist_word_t             rdata_q;
  logic                            rvld_q;
  logic [gss_pkg::SlotW-1:0]       rd_addr;

  logic                            p1_vld_q;
  logic                            p1_last_q;
  logic [gss_pkg::SlotW-1:0]       p1_tap_q;
  logic                            p2_vld_q;
  logic                            p2_last_q;
  logic                            acc_done_q;
  logic signed [gss_pkg::ProdW-1:0] prod_d [gss_pkg::NumChan];
  logic signed [gss_pkg::ProdW-1:0] prod_q [gss_pkg::NumChan];
  logic signed [gss_pkg::AccW-1:0]  acc_q  [gss_pkg::NumChan];
  gss_pkg::hist_word_t             result;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  // Round to nearest, ties upwards, then clamp to the channel's range.
  function automatic logic [gss_pkg::SampleW-1:0] round_sat(
    input logic signed [gss_pkg::AccW-1:0] acc,
    input logic                            is_signed
  );
    logic signed [gss_pkg::AccW-1:0] biased;
    logic signed [QW-1:0]            q;
    logic signed [QW-1:0]            lo;
    logic signed [QW-1:0]            hi;
    logic [gss_pkg::SampleW-1:0]     r;
    biased = acc + gss_pkg::AccW'(1 << (gss_pkg::FracW - 1));
    q      = biased[gss_pkg::AccW-1:gss_pkg::FracW];
    lo     = is_signed ? -(QW'(1) << (gss_pkg::SampleW - 1)) : '0;
    hi     = is_signed ? (QW'(1) << (gss_pkg::SampleW - 1)) - QW'(1)
                       : (QW'(1) << gss_pkg::SampleW) - QW'(1);
    if (q < lo) begin
      r = lo[gss_pkg::SampleW-1:0];
    end else if (q > hi) begin
      r = hi[gss_pkg::SampleW-1:0];
    end else begin
      r = q[gss_pkg::SampleW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gss_pkg::NumWeights; i++) begin
        weight_q[i] <= gss_pkg::weight_reset(gss_pkg::WIdxW'(i));
      end
    end else if (cfg_valid_i && cfg_index_i < gss_pkg::CfgIdxW'(gss_pkg::NumWeights)) begin
      weight_q[cfg_index_i[gss_pkg::WIdxW-1:0]] <= cfg_data_i;
    end
  end

  // Control and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      slot_q     <= '0;
      tap_q      <= '0;
      vld_q      <= '0;
      fill_q     <= '0;
      is_start_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (out_vld_q && m_axis_tready && state_q != StFinish) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == gss_pkg::ActStart) begin
              // An entry without its valid bit reads as the fill value.
              fill_q     <= s_axis_tdata;
              vld_q      <= '0;
              slot_q     <= '0;
              is_start_q <= 1'b1;
              state_q    <= StFinish;
            end else begin
              slot_q     <= slot_q + 1'b1;
              is_start_q <= 1'b0;
              state_q    <= StWrite;
            end
          end
        end
        StWrite: begin
          vld_q[slot_q] <= 1'b1;
          tap_q         <= '0;
          state_q       <= StRead;
        end
        StRead: begin
          tap_q <= tap_q + 1'b1;
          if (tap_q == TapLast) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (acc_done_q) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (!out_vld_q || m_axis_tready) begin
            out_q     <= result;
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
  end

  // History memory: one write port, one registered read port.
  assign rd_addr = slot_q - tap_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StWrite) begin
      hist_mem[slot_q] <= in_q;
    end
    rdata_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q     <= 1'b0;
      p1_vld_q   <= 1'b0;
      p1_last_q  <= 1'b0;
      p1_tap_q   <= '0;
      p2_vld_q   <= 1'b0;
      p2_last_q  <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      rvld_q     <= vld_q[rd_addr];
      p1_vld_q   <= (state_q == StRead);
      p1_last_q  <= (tap_q == TapLast);
      p1_tap_q   <= tap_q;
      p2_vld_q   <= p1_vld_q;
      p2_last_q  <= p1_last_q;
      acc_done_q <= p2_vld_q && p2_last_q;
    end
  end

  always_comb begin
    logic [gss_pkg::SampleW-1:0] s;
    for (int c = 0; c < gss_pkg::NumChan; c++) begin
      s = rvld_q ? rdata_q[c] : fill_q[c];
      prod_d[c] = $signed({gss_pkg::ChanSigned[c] & s[gss_pkg::SampleW-1], s})
                * $signed({1'b0, weight_q[p1_tap_q]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < gss_pkg::NumChan; c++) begin
      prod_q[c] <= prod_d[c];
      if (state_q == StWrite) begin
        acc_q[c] <= '0;
      end else if (p2_vld_q) begin
        acc_q[c] <= acc_q[c] + gss_pkg::AccW'(prod_q[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < gss_pkg::NumChan; c++) begin
      result[c] = is_start_q ? in_q[c] : round_sat(acc_q[c], gss_pkg::ChanSigned[c]);
    end
  end

endmodule

/* src/gss_checker.sv */
module gss_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [gss_pkg::DataW-1:0]    s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [gss_pkg::DataW-1:0]    m_axis_tdata
);

  // Only one word is in work at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in work");

  // A start word accepted while the output is free comes back unchanged via StFinish.
  a_start_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == gss_pkg::ActStart
      && !m_axis_tvalid
    |-> ##2 m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata, 2))
    else $error("start word not returned unchanged");

  // A result only appears for a word in work.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result word without a word in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind gaussian_stylus_smoother_top gss_checker u_gss_checker (.*);
